### rtl/core/gdb_pkg.sv
// ----------------------------------------------------------------------------
// gdb_pkg
// Shared types, codes and helpers for the graph traversal unit.
// ----------------------------------------------------------------------------
package gdb_pkg;

	localparam int MAX_VERTICES_DEF = 64;   // also the upper limit of MAX_VERTICES
	localparam int VERT_W           = 7;
	localparam int IDX_W            = 6;
	localparam int CFG_IDX_W        = 2;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	typedef logic [VERT_W-1:0] vert_t;

	// command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSAL_MODE = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		vert_t      end_a;
		vert_t      end_b;
	} in_t;

	typedef struct packed {
		vert_t visited_vertex;
		logic  last;
		logic  bad_start;
	} result_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ADD,
		OP_RUN,
		OP_BAD_START
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		vert_t    end_a;
		vert_t    end_b;
	} op_t;

	// index of the lowest set bit, zero when none is set
	function automatic logic [IDX_W-1:0] lowest_index(input logic [MAX_VERTICES_DEF-1:0] x);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = MAX_VERTICES_DEF - 1; i >= 0; i--) begin
			if (x[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### rtl/core/graph_dfs_bfs_visit_order_unit.sv
// ----------------------------------------------------------------------------
// graph_dfs_bfs_visit_order_unit
// Undirected graph traversal: builds an adjacency bit matrix from add-edge
// items and emits depth first or breadth first visit order on run items.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  in        | input     | in_valid / in_ready    | in_data  (command, end_a, end_b)
//  out       | output    | out_valid / out_ready  | out_data (visited_vertex, last, bad_start)
//  cfg       | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Clear is done by the engine in its idle state; add edge is two
//  read-modify-writes of the adjacency row memory through its one read and
//  one write port. A depth first run steps through row read, evaluate and
//  stack pop per vertex; breadth first steps through queue head read, row
//  load and a scan that queues each neighbor, bounded by the one read port
//  of the adjacency and walk memories. Reset clears the rows at once through
//  per-row valid bits, so no clearing pass is needed. A 2-entry op queue
//  keeps taking items while the engine runs or the output register is
//  stalled, until it is full.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_visit_order_unit #(
	parameter int MAX_VERTICES = gdb_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gdb_pkg::in_t                      in_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	output gdb_pkg::result_t                  out_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gdb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  gdb_pkg::vert_t                    cfg_data
);
	import gdb_pkg::*;

	vert_t vertex_count_q;
	vert_t start_vertex_q;
	logic  mode_q;
	vert_t active_n;
	op_t   op;
	logic  op_valid;
	logic  op_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= vert_t'(64);
			start_vertex_q <= vert_t'(1);
			mode_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VERTEX_COUNT:   vertex_count_q <= cfg_data;
				CFG_START_VERTEX:   start_vertex_q <= cfg_data;
				CFG_TRAVERSAL_MODE: mode_q         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// counts above the built size act as the built size
	assign active_n = (vertex_count_q > vert_t'(MAX_VERTICES)) ? vert_t'(MAX_VERTICES)
	                                                          : vertex_count_q;

	gdb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_data      (in_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.active_n     (active_n),
		.start_vertex (start_vertex_q),
		.op           (op),
		.op_valid     (op_valid),
		.op_ready     (op_ready)
	);

	gdb_back #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.active_n     (active_n),
		.start_vertex (start_vertex_q),
		.mode         (mode_q),
		.out_data     (out_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule

### rtl/core/gdb_front.sv
// ----------------------------------------------------------------------------
// gdb_front
// Accepts command items, decodes and range checks them, and queues the
// resulting operations for the traversal engine.
// ----------------------------------------------------------------------------
module gdb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  gdb_pkg::in_t   in_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdb_pkg::vert_t active_n,
	input  gdb_pkg::vert_t start_vertex,
	output gdb_pkg::op_t   op,
	output logic           op_valid,
	input  logic           op_ready
);
	import gdb_pkg::*;

	op_t               q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	op_t  op_new;
	logic keep;
	logic a_ok;
	logic b_ok;
	logic push;
	logic pop;

	assign a_ok = (in_data.end_a != '0) && (in_data.end_a <= active_n);
	assign b_ok = (in_data.end_b != '0) && (in_data.end_b <= active_n);

	always_comb begin
		op_new.end_a = in_data.end_a;
		op_new.end_b = in_data.end_b;
		op_new.kind  = OP_CLEAR;
		keep         = 1'b0;
		unique case (in_data.command)
			CMD_CLEAR: begin
				keep = 1'b1;
			end
			CMD_ADD: begin
				op_new.kind = OP_ADD;
				keep        = a_ok && b_ok;
			end
			CMD_RUN: begin
				keep = 1'b1;
				if (start_vertex == '0 || start_vertex > active_n) begin
					op_new.kind = OP_BAD_START;
				end else begin
					op_new.kind = OP_RUN;
				end
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready && keep;
	assign op_valid = (count_q != '0);
	assign pop      = op_valid && op_ready;
	assign op       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("op queue overfilled");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queued op lost");
`endif

endmodule

### rtl/core/gdb_back.sv
// ----------------------------------------------------------------------------
// gdb_back
// Traversal engine: adjacency row memory, walk stack/queue memory and the
// sequencer that carries out clear, add edge and run operations.
// ----------------------------------------------------------------------------
module gdb_back #(
	parameter int MAX_VERTICES = gdb_pkg::MAX_VERTICES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gdb_pkg::op_t     op,
	input  logic             op_valid,
	output logic             op_ready,
	input  gdb_pkg::vert_t   active_n,
	input  gdb_pkg::vert_t   start_vertex,
	input  logic             mode,
	output gdb_pkg::result_t out_data,
	output logic             out_valid,
	input  logic             out_ready
);
	import gdb_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	typedef logic [VW-1:0]           vidx_t;
	typedef logic [CW-1:0]           cnt_t;
	typedef logic [MAX_VERTICES-1:0] vmask_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_B,
		ST_ADD_WB,
		ST_DFS_EVAL,
		ST_DFS_POP,
		ST_BFS_HEAD,
		ST_BFS_CUR,
		ST_BFS_LOAD,
		ST_BFS_SCAN,
		ST_FINISH,
		ST_BAD
	} state_t;

	state_t state_q;

	// adjacency rows, one valid bit per row
	vmask_t adj_mem [MAX_VERTICES];
	vmask_t row_vld_q;
	vmask_t adj_rd_q;
	logic   row_vld_rd_q;
	vidx_t  adj_ra;
	vidx_t  adj_wa;
	vmask_t adj_wd;
	logic   adj_we;
	logic   clear;

	// walk stack (depth first) or queue (breadth first)
	vidx_t  ws_mem [MAX_VERTICES];
	vidx_t  ws_rd_q;
	vidx_t  ws_ra;
	vidx_t  ws_wa;
	vidx_t  ws_wd;
	logic   ws_we;

	vmask_t  vmask_q;
	vmask_t  visited_q;
	vmask_t  cand_q;
	vidx_t   top_q;
	vidx_t   pend_q;
	vidx_t   a_q;
	vidx_t   b_q;
	cnt_t    depth_q;
	cnt_t    head_q;
	cnt_t    tail_q;
	cnt_t    depth_m2;
	result_t out_data_q;
	logic    out_valid_q;

	vmask_t adj_row;
	vmask_t cand;
	vidx_t  nx;
	vidx_t  nx_scan;
	vidx_t  s_idx;
	vidx_t  a_in;
	vidx_t  b_in;
	logic   can_push;

	assign s_idx    = vidx_t'(start_vertex - vert_t'(1));
	assign a_in     = vidx_t'(op.end_a - vert_t'(1));
	assign b_in     = vidx_t'(op.end_b - vert_t'(1));
	assign adj_row  = row_vld_rd_q ? adj_rd_q : '0;
	assign cand     = adj_row & vmask_q & ~visited_q;
	assign nx       = vidx_t'(lowest_index(MAX_VERTICES_DEF'(cand)));
	assign nx_scan  = vidx_t'(lowest_index(MAX_VERTICES_DEF'(cand_q)));
	assign depth_m2 = depth_q - cnt_t'(2);
	assign can_push = !out_valid_q || out_ready;
	assign op_ready = (state_q == ST_IDLE);
	assign clear    = (state_q == ST_IDLE) && op_valid && (op.kind == OP_CLEAR);
	assign out_data  = out_data_q;
	assign out_valid = out_valid_q;

	always_comb begin
		adj_ra = top_q;
		adj_we = 1'b0;
		adj_wa = a_q;
		adj_wd = adj_row | (vmask_t'(1) << b_q);
		ws_we  = 1'b0;
		ws_wa  = '0;
		ws_wd  = nx;
		ws_ra  = head_q[VW-1:0];
		case (state_q)
			ST_IDLE: begin
				adj_ra = (op.kind == OP_ADD) ? a_in : s_idx;
				if (op_valid && op.kind == OP_RUN) begin
					ws_we = 1'b1;
					ws_wd = s_idx;
				end
			end
			ST_ADD_B: begin
				adj_we = 1'b1;
				adj_ra = b_q;
			end
			ST_ADD_WB: begin
				adj_we = 1'b1;
				adj_wa = b_q;
				adj_wd = adj_row | (vmask_t'(1) << a_q);
			end
			ST_DFS_EVAL: begin
				if (cand != '0) begin
					if (can_push) begin
						adj_ra = nx;
						ws_we  = 1'b1;
						ws_wa  = depth_q[VW-1:0];
					end
				end else begin
					ws_ra = depth_m2[VW-1:0];
				end
			end
			ST_DFS_POP: begin
				adj_ra = ws_rd_q;
			end
			ST_BFS_CUR: begin
				adj_ra = ws_rd_q;
			end
			ST_BFS_SCAN: begin
				if (cand_q != '0) begin
					ws_we = 1'b1;
					ws_wa = tail_q[VW-1:0];
					ws_wd = nx_scan;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		adj_rd_q     <= adj_mem[adj_ra];
		row_vld_rd_q <= row_vld_q[adj_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (clear) begin
			row_vld_q <= '0;
		end else if (adj_we) begin
			row_vld_q[adj_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ws_we) begin
			ws_mem[ws_wa] <= ws_wd;
		end
		ws_rd_q <= ws_mem[ws_ra];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vmask_q[i] <= (vert_t'(i) < active_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						unique case (op.kind)
							OP_CLEAR: begin
							end
							OP_ADD: begin
								a_q     <= a_in;
								b_q     <= b_in;
								state_q <= ST_ADD_B;
							end
							OP_RUN: begin
								visited_q <= vmask_t'(1) << s_idx;
								top_q     <= s_idx;
								pend_q    <= s_idx;
								depth_q   <= cnt_t'(1);
								head_q    <= '0;
								tail_q    <= cnt_t'(1);
								state_q   <= mode ? ST_BFS_HEAD : ST_DFS_EVAL;
							end
							OP_BAD_START: begin
								state_q <= ST_BAD;
							end
						endcase
					end
				end
				ST_ADD_B: begin
					state_q <= ST_ADD_WB;
				end
				ST_ADD_WB: begin
					state_q <= ST_IDLE;
				end
				ST_DFS_EVAL: begin
					if (cand != '0) begin
						if (can_push) begin
							out_data_q.visited_vertex <= vert_t'(pend_q) + vert_t'(1);
							out_data_q.last           <= 1'b0;
							out_data_q.bad_start      <= 1'b0;
							out_valid_q               <= 1'b1;
							pend_q                    <= nx;
							visited_q                 <= visited_q | (vmask_t'(1) << nx);
							depth_q                   <= depth_q + cnt_t'(1);
							top_q                     <= nx;
						end
					end else if (depth_q == cnt_t'(1)) begin
						state_q <= ST_FINISH;
					end else begin
						depth_q <= depth_q - cnt_t'(1);
						state_q <= ST_DFS_POP;
					end
				end
				ST_DFS_POP: begin
					top_q   <= ws_rd_q;
					state_q <= ST_DFS_EVAL;
				end
				ST_BFS_HEAD: begin
					state_q <= (head_q == tail_q) ? ST_FINISH : ST_BFS_CUR;
				end
				ST_BFS_CUR: begin
					// the start vertex is already held as the first result
					if (ws_rd_q == s_idx) begin
						head_q  <= head_q + cnt_t'(1);
						state_q <= ST_BFS_LOAD;
					end else if (can_push) begin
						out_data_q.visited_vertex <= vert_t'(pend_q) + vert_t'(1);
						out_data_q.last           <= 1'b0;
						out_data_q.bad_start      <= 1'b0;
						out_valid_q               <= 1'b1;
						pend_q                    <= ws_rd_q;
						head_q                    <= head_q + cnt_t'(1);
						state_q                   <= ST_BFS_LOAD;
					end
				end
				ST_BFS_LOAD: begin
					cand_q  <= cand;
					state_q <= ST_BFS_SCAN;
				end
				ST_BFS_SCAN: begin
					if (cand_q == '0) begin
						state_q <= ST_BFS_HEAD;
					end else begin
						cand_q    <= cand_q & ~(vmask_t'(1) << nx_scan);
						visited_q <= visited_q | (vmask_t'(1) << nx_scan);
						tail_q    <= tail_q + cnt_t'(1);
					end
				end
				ST_FINISH: begin
					if (can_push) begin
						out_data_q.visited_vertex <= vert_t'(pend_q) + vert_t'(1);
						out_data_q.last           <= 1'b1;
						out_data_q.bad_start      <= 1'b0;
						out_valid_q               <= 1'b1;
						state_q                   <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (can_push) begin
						out_data_q.visited_vertex <= '0;
						out_data_q.last           <= 1'b1;
						out_data_q.bad_start      <= 1'b1;
						out_valid_q               <= 1'b1;
						state_q                   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DFS_EVAL |-> visited_q[top_q])
		else $error("stack top not marked visited");

	a_bad_start_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.bad_start |-> out_data_q.last &&
			out_data_q.visited_vertex == '0)
		else $error("malformed bad start result");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BFS_HEAD |-> head_q <= tail_q && tail_q <= cnt_t'(MAX_VERTICES))
		else $error("walk queue pointers out of order");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DFS_EVAL |-> depth_q != '0 && depth_q <= cnt_t'(MAX_VERTICES))
		else $error("walk stack depth out of range");
`endif

endmodule
